/* rtl/encoder_position_speed_filter_defines.svh */
// Assertion helpers used by the top-level RTL file.
`ifndef ENCODER_POSITION_SPEED_FILTER_DEFINES_SVH
`define ENCODER_POSITION_SPEED_FILTER_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define EPSF_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define EPSF_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/epsf_pkg.sv */
`default_nettype none

package epsf_pkg;

  localparam int POS_W        = 10;
  localparam int ANGLE_W      = 9;
  localparam int SPEED_W      = 11;
  localparam int CFG_IDX_W    = 2;
  localparam int DEF_WINDOW   = 4;
  localparam int DEF_CHANNELS = 2;
  localparam int FULL_TURN    = 1024;
  localparam int HALF_TURN    = 512;
  localparam int DEG_MUL      = 45;
  localparam int DEG_MUL_W    = 6;
  localparam int DEG_SHIFT    = 7;
  localparam int THRESH_RESET = 50;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ZERO_OFFSET_A  = 2'd0,
    REG_ZERO_OFFSET_B  = 2'd1,
    REG_JUMP_THRESHOLD = 2'd2
  } cfg_reg_t;

  // Position update handed from the tracker to the window filter.
  typedef struct packed {
    logic             fire;
    logic [POS_W-1:0] pos;
  } pos_upd_t;

endpackage

`default_nettype wire

/* rtl/epsf_track.sv */
`default_nettype none

module epsf_track import epsf_pkg::*; #(
  parameter int CHANNELS = DEF_CHANNELS,
  parameter int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      fire,
  input  logic                      channel,
  input  logic [CH_W-1:0]           ch_idx,
  input  logic [POS_W-1:0]          raw_position,
  input  logic [POS_W-1:0]          zero_offset_a,
  input  logic [POS_W-1:0]          zero_offset_b,
  output logic [POS_W-1:0]          position,
  output logic [ANGLE_W-1:0]        angle_degrees,
  output logic signed [SPEED_W-1:0] speed,
  output pos_upd_t                  upd
);

  localparam int PROD_W = POS_W + DEG_MUL_W;
  localparam int D_W    = POS_W + 2;

  logic [POS_W-1:0]        last_position [CHANNELS];
  logic [POS_W-1:0]        offset;
  logic [PROD_W-1:0]       prod;
  logic signed [D_W-1:0]   diff;
  logic signed [D_W-1:0]   diff_wrap;

  always_comb begin
    offset   = (channel == 1'b0) ? zero_offset_a : zero_offset_b;
    // modulo 1024 falls out of the 10-bit subtract
    position = raw_position - offset;
    prod     = PROD_W'(position) * PROD_W'(DEG_MUL);
    angle_degrees = prod[DEG_SHIFT +: ANGLE_W];
  end

  // Take the shorter way round; a tie at the half turn flips sign.
  always_comb begin
    diff = $signed({2'b00, position}) - $signed({2'b00, last_position[ch_idx]});
    if (diff >= $signed(D_W'(HALF_TURN))) begin
      diff_wrap = diff - $signed(D_W'(FULL_TURN));
    end else if (diff <= -$signed(D_W'(HALF_TURN))) begin
      diff_wrap = diff + $signed(D_W'(FULL_TURN));
    end else begin
      diff_wrap = diff;
    end
    speed = diff_wrap[SPEED_W-1:0];
  end

  assign upd.fire = fire;
  assign upd.pos  = position;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        last_position[i] <= '0;
      end
    end else if (fire) begin
      last_position[ch_idx] <= position;
    end
  end

endmodule

`default_nettype wire

/* rtl/epsf_window.sv */
`default_nettype none

module epsf_window import epsf_pkg::*; #(
  parameter int WINDOW   = DEF_WINDOW,
  parameter int CHANNELS = DEF_CHANNELS,
  parameter int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  pos_upd_t         upd,
  input  logic [CH_W-1:0]  ch_idx,
  input  logic [POS_W-1:0] jump_threshold,
  output logic [POS_W-1:0] filtered_position
);

  localparam int SUM_W   = POS_W + $clog2(WINDOW);
  localparam int SH      = SUM_W + $clog2(WINDOW);
  localparam int RECIP   = ((1 << SH) + WINDOW - 1) / WINDOW;
  localparam int MPROD_W = SUM_W + SH;

  // Per channel shift line: tap 0 newest, tap WINDOW-1 oldest.
  logic [POS_W-1:0]   taps    [CHANNELS][WINDOW];
  logic [SUM_W-1:0]   run_sum [CHANNELS];

  logic [POS_W-1:0]   dropped;
  logic [POS_W-1:0]   oldest;
  logic [POS_W-1:0]   jump;
  logic [SUM_W-1:0]   sum_next;
  logic [MPROD_W-1:0] mprod;
  logic [POS_W-1:0]   average;

  always_comb begin
    dropped  = taps[ch_idx][WINDOW-1];
    oldest   = taps[ch_idx][WINDOW-2];
    sum_next = run_sum[ch_idx] + SUM_W'(upd.pos) - SUM_W'(dropped);
    // exact divide by WINDOW through a rounded-up reciprocal
    mprod    = MPROD_W'(sum_next) * MPROD_W'(RECIP);
    average  = mprod[SH +: POS_W];
    jump     = (upd.pos > oldest) ? (upd.pos - oldest) : (oldest - upd.pos);
    filtered_position = (jump > jump_threshold) ? oldest : average;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        run_sum[c] <= '0;
        for (int k = 0; k < WINDOW; k++) begin
          taps[c][k] <= '0;
        end
      end
    end else if (upd.fire) begin
      run_sum[ch_idx] <= sum_next;
      taps[ch_idx][0] <= upd.pos;
      for (int k = 1; k < WINDOW; k++) begin
        taps[ch_idx][k] <= taps[ch_idx][k-1];
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/encoder_position_speed_filter.sv */
//  channel   direction  handshake            payload
//  request   in         req_valid/req_ready  channel, raw_position
//  result    out        res_valid/res_ready  channel_out, position, angle_degrees,
//                                            speed, filtered_position
//  config    in         cfg_write            cfg_index, cfg_data
//
//  One request per cycle sustained while results are drained; a request lands in the
//  input register, and its result then moves into the result register.
//  Per-channel state (last position, shift line, running sum) updates as the request
//  moves into the result register, so a back-to-back request sees it at once.
//  A stalled result holds; the input register still takes a request once it drains.
//  rst is synchronous and resets state, settings and valid flags; no clearing pass.
`default_nettype none

`include "encoder_position_speed_filter_defines.svh"

module encoder_position_speed_filter import epsf_pkg::*; #(
  parameter int WINDOW   = DEF_WINDOW,
  parameter int CHANNELS = DEF_CHANNELS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [POS_W-1:0]          cfg_data,
  input  logic                      req_valid,
  output logic                      req_ready,
  input  logic                      channel,
  input  logic [POS_W-1:0]          raw_position,
  output logic                      res_valid,
  input  logic                      res_ready,
  output logic                      channel_out,
  output logic [POS_W-1:0]          position,
  output logic [ANGLE_W-1:0]        angle_degrees,
  output logic signed [SPEED_W-1:0] speed,
  output logic [POS_W-1:0]          filtered_position
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // configuration
  logic [POS_W-1:0] zero_offset_a;
  logic [POS_W-1:0] zero_offset_b;
  logic [POS_W-1:0] jump_threshold;

  // input register
  logic             s1_valid;
  logic             s1_channel;
  logic [POS_W-1:0] s1_raw;

  logic             res_load;
  logic             s1_adv;
  logic [CH_W-1:0]  ch_idx;

  logic [POS_W-1:0]          calc_pos;
  logic [ANGLE_W-1:0]        calc_angle;
  logic signed [SPEED_W-1:0] calc_speed;
  logic [POS_W-1:0]          calc_filt;
  pos_upd_t                  upd;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_offset_a  <= '0;
      zero_offset_b  <= '0;
      jump_threshold <= POS_W'(THRESH_RESET);
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ZERO_OFFSET_A:  zero_offset_a  <= cfg_data;
        REG_ZERO_OFFSET_B:  zero_offset_b  <= cfg_data;
        REG_JUMP_THRESHOLD: jump_threshold <= cfg_data;
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // Result register loads when empty or being drained; the input register
  // advances into it, and refills in the same cycle.
  assign res_load  = !res_valid || res_ready;
  assign s1_adv    = s1_valid && res_load;
  assign req_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_ready) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      s1_channel <= channel;
      s1_raw     <= raw_position;
    end
  end

  // Channels past the configured count fold onto the last one.
  always_comb begin
    if (int'(s1_channel) < CHANNELS) begin
      ch_idx = CH_W'(s1_channel);
    end else begin
      ch_idx = CH_W'(CHANNELS - 1);
    end
  end

  epsf_track #(
    .CHANNELS (CHANNELS),
    .CH_W     (CH_W)
  ) u_track (
    .clk           (clk),
    .rst           (rst),
    .fire          (s1_adv),
    .channel       (s1_channel),
    .ch_idx        (ch_idx),
    .raw_position  (s1_raw),
    .zero_offset_a (zero_offset_a),
    .zero_offset_b (zero_offset_b),
    .position      (calc_pos),
    .angle_degrees (calc_angle),
    .speed         (calc_speed),
    .upd           (upd)
  );

  epsf_window #(
    .WINDOW   (WINDOW),
    .CHANNELS (CHANNELS),
    .CH_W     (CH_W)
  ) u_window (
    .clk               (clk),
    .rst               (rst),
    .upd               (upd),
    .ch_idx            (ch_idx),
    .jump_threshold    (jump_threshold),
    .filtered_position (calc_filt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      channel_out       <= s1_channel;
      position          <= calc_pos;
      angle_degrees     <= calc_angle;
      speed             <= calc_speed;
      filtered_position <= calc_filt;
    end
  end

  `EPSF_ASSERT_NXT(a_adv_shows_result, clk, rst, s1_adv, res_valid, "advanced request lost")
  `EPSF_ASSERT_IMP(a_full_blocks_req, clk, rst, s1_valid && res_valid && !res_ready, !req_ready, "request taken while full")
  `EPSF_ASSERT_IMP(a_angle_range, clk, rst, res_valid, angle_degrees <= 9'd359, "angle out of range")
  `EPSF_ASSERT_IMP(a_speed_range, clk, rst, res_valid, speed[SPEED_W-1:0] != 11'h400, "speed out of range")

endmodule

`default_nettype wire

/* tb/encoder_position_speed_filter_tb.sv */
`timescale 1ns / 1ps

module encoder_position_speed_filter_tb;
  import epsf_pkg::*;

  localparam int RING_DEPTH   = DEF_WINDOW;
  localparam int CHAN_COUNT   = DEF_CHANNELS;
  localparam int PHASE_ITEMS  = 300;
  localparam int PHASE_COUNT  = 6;
  // Index 3 decodes to no register; writes to it must leave every setting alone.
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  // Idle modes: sender 35% / receiver 45%, then swapped, then free running.
  localparam int IDLE_SEND_LIGHT = 0;
  localparam int IDLE_SEND_HEAVY = 1;
  localparam int IDLE_NONE       = 2;

  typedef struct packed {
    logic             ch;
    logic [POS_W-1:0] raw;
  } reading_req_t;

  typedef struct packed {
    logic                      ch;
    logic [POS_W-1:0]          pos;
    logic [ANGLE_W-1:0]        angle;
    logic signed [SPEED_W-1:0] spd;
    logic [POS_W-1:0]          filt;
  } reading_result_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = REG_ZERO_OFFSET_A;
  logic [POS_W-1:0]          cfg_data = '0;
  logic                      req_valid = 1'b0;
  logic                      req_ready;
  logic                      channel = 1'b0;
  logic [POS_W-1:0]          raw_position = '0;
  logic                      res_valid;
  logic                      res_ready = 1'b0;
  logic                      channel_out;
  logic [POS_W-1:0]          position;
  logic [ANGLE_W-1:0]        angle_degrees;
  logic signed [SPEED_W-1:0] speed;
  logic [POS_W-1:0]          filtered_position;

  encoder_position_speed_filter dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .req_valid         (req_valid),
    .req_ready         (req_ready),
    .channel           (channel),
    .raw_position      (raw_position),
    .res_valid         (res_valid),
    .res_ready         (res_ready),
    .channel_out       (channel_out),
    .position          (position),
    .angle_degrees     (angle_degrees),
    .speed             (speed),
    .filtered_position (filtered_position)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow copy of the block: settings plus per-channel tracking state.
  logic [POS_W-1:0] off_a = '0;
  logic [POS_W-1:0] off_b = '0;
  logic [POS_W-1:0] thresh = POS_W'(THRESH_RESET);
  logic [POS_W-1:0] last_pos [CHAN_COUNT];
  logic [POS_W-1:0] ring_pos [CHAN_COUNT][RING_DEPTH];
  int               ring_slot [CHAN_COUNT];

  reading_req_t    pending_reads [$];
  reading_result_t expected_readings [$];

  int idle_mode = IDLE_SEND_LIGHT;
  int mismatches = 0;
  int readings_sent = 0;
  int results_checked = 0;
  int settings_written = 0;
  logic [POS_W-1:0] raw_walk [CHAN_COUNT];

  initial begin
    for (int c = 0; c < CHAN_COUNT; c++) begin
      last_pos[c] = '0;
      ring_slot[c] = 0;
      raw_walk[c] = '0;
      for (int i = 0; i < RING_DEPTH; i++) ring_pos[c][i] = '0;
    end
  end

  // Advance the shadow state by one reading and return what the block must show.
  function automatic reading_result_t track_reading(input logic ch,
                                                    input logic [POS_W-1:0] raw);
    reading_result_t  r;
    logic [POS_W-1:0] off, pos, oldest, gap, mean;
    int               delta, sum, slot, nxt;
    off = ch ? off_b : off_a;
    pos = raw - off;
    // Take the shorter way round; an exact half turn flips sign.
    delta = int'(pos) - int'(last_pos[ch]);
    if (delta >= HALF_TURN) delta = delta - FULL_TURN;
    else if (delta <= -HALF_TURN) delta = delta + FULL_TURN;
    slot = ring_slot[ch];
    nxt = (slot + 1) % RING_DEPTH;
    last_pos[ch] = pos;
    ring_pos[ch][slot] = pos;
    ring_slot[ch] = nxt;
    sum = 0;
    for (int i = 0; i < RING_DEPTH; i++) sum += int'(ring_pos[ch][i]);
    mean = POS_W'(sum / RING_DEPTH);
    // The oldest entry is the slot the next write of this channel overwrites.
    oldest = ring_pos[ch][nxt];
    gap = (pos > oldest) ? pos - oldest : oldest - pos;
    r.ch = ch;
    r.pos = pos;
    r.angle = ANGLE_W'((int'(pos) * DEG_MUL) >> DEG_SHIFT);
    r.spd = SPEED_W'(delta);
    r.filt = (gap > thresh) ? oldest : mean;
    return r;
  endfunction

  function automatic bit pause_roll(input bit is_sender);
    int pct;
    case (idle_mode)
      IDLE_SEND_LIGHT: pct = is_sender ? 35 : 45;
      IDLE_SEND_HEAVY: pct = is_sender ? 45 : 35;
      default:         pct = 0;
    endcase
    return $urandom_range(99) < pct;
  endfunction

  // Request driver: predict on accept, hold while stalled, else load the next request.
  always @(posedge clk) begin
    reading_req_t nxt;
    if (req_valid && req_ready) begin
      expected_readings.push_back(track_reading(channel, raw_position));
      readings_sent++;
    end
    if (!(req_valid && !req_ready)) begin
      if (pending_reads.size() != 0 && !pause_roll(1'b1)) begin
        nxt = pending_reads.pop_front();
        req_valid <= 1'b1;
        channel <= nxt.ch;
        raw_position <= nxt.raw;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Result monitor: compare against the oldest expectation, then roll the stall.
  always @(posedge clk) begin
    reading_result_t want;
    if (!rst && res_valid && res_ready) begin
      if (expected_readings.size() == 0) begin
        $error("result arrived with no request outstanding");
        mismatches++;
      end else begin
        want = expected_readings.pop_front();
        results_checked++;
        if (channel_out !== want.ch) begin
          $error("channel_out: expected %0d, got %0d", want.ch, channel_out);
          mismatches++;
        end
        if (position !== want.pos) begin
          $error("position: expected %0d, got %0d", want.pos, position);
          mismatches++;
        end
        if (angle_degrees !== want.angle) begin
          $error("angle_degrees: expected %0d, got %0d", want.angle, angle_degrees);
          mismatches++;
        end
        if (speed !== want.spd) begin
          $error("speed: expected %0d, got %0d", $signed(want.spd), $signed(speed));
          mismatches++;
        end
        if (filtered_position !== want.filt) begin
          $error("filtered_position: expected %0d, got %0d", want.filt,
                 filtered_position);
          mismatches++;
        end
      end
    end
    res_ready <= !pause_roll(1'b0);
  end

  task automatic queue_reading(input logic ch, input logic [POS_W-1:0] raw);
    reading_req_t q;
    q.ch = ch;
    q.raw = raw;
    pending_reads.push_back(q);
  endtask

  // Block until every request has gone out and every result has come back,
  // then let the two-stage pipe settle before touching the registers.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_reads.size() != 0 || req_valid || expected_readings.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Write all three registers plus the unmapped index, one per cycle.
  task automatic write_settings(input logic [POS_W-1:0] a, input logic [POS_W-1:0] b,
                                input logic [POS_W-1:0] thr);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_ZERO_OFFSET_A;
    cfg_data <= a;
    @(posedge clk);
    cfg_index <= REG_ZERO_OFFSET_B;
    cfg_data <= b;
    @(posedge clk);
    cfg_index <= REG_JUMP_THRESHOLD;
    cfg_data <= thr;
    @(posedge clk);
    cfg_index <= REG_UNMAPPED;
    cfg_data <= POS_W'($urandom_range(1023));
    @(posedge clk);
    cfg_write <= 1'b0;
    off_a = a;
    off_b = b;
    thresh = thr;
    settings_written++;
    @(negedge clk);
  endtask

  // Random reading: mostly a smooth walk per channel, with jumps and noise.
  task automatic queue_random_reading();
    logic             ch;
    logic [POS_W-1:0] stepv;
    int               pick;
    ch = 1'($urandom_range(1));
    pick = $urandom_range(99);
    if (pick < 60) stepv = POS_W'($urandom_range(40) - 20);
    else if (pick < 78) stepv = POS_W'($urandom_range(240) - 120);
    else if (pick < 82) stepv = POS_W'(HALF_TURN);
    else stepv = POS_W'($urandom_range(1023));
    if (pick >= 82) raw_walk[ch] = stepv;
    else raw_walk[ch] = raw_walk[ch] + stepv;
    queue_reading(ch, raw_walk[ch]);
  endtask

  initial begin
    logic [POS_W-1:0] a, b, thr;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: ring filling from zeros, half-turn ties both ways,
    // wrap at the top of the range, full-scale angle.
    idle_mode = IDLE_SEND_LIGHT;
    queue_reading(1'b0, 10'd0);
    queue_reading(1'b0, 10'd512);
    queue_reading(1'b0, 10'd0);
    queue_reading(1'b0, 10'd1023);
    queue_reading(1'b0, 10'd0);
    queue_reading(1'b0, 10'd1);
    queue_reading(1'b0, 10'd2);
    queue_reading(1'b0, 10'd3);
    queue_reading(1'b1, 10'd1023);
    queue_reading(1'b1, 10'd1023);
    queue_reading(1'b1, 10'd1023);
    queue_reading(1'b1, 10'd1023);
    queue_reading(1'b1, 10'd0);
    wait_drained();

    // Extreme offsets and a zero threshold: every move bypasses the average.
    write_settings(10'd1023, 10'd1, 10'd0);
    queue_reading(1'b0, 10'd0);
    queue_reading(1'b1, 10'd0);
    queue_reading(1'b0, 10'd1023);
    queue_reading(1'b1, 10'd1);
    queue_reading(1'b0, 10'd512);
    queue_reading(1'b1, 10'd513);
    queue_reading(1'b1, 10'd1);
    queue_reading(1'b0, 10'd511);
    wait_drained();

    for (int p = 0; p < PHASE_COUNT; p++) begin
      idle_mode = (p < 2) ? IDLE_SEND_LIGHT : (p < 4) ? IDLE_SEND_HEAVY : IDLE_NONE;
      a = POS_W'($urandom_range(1023));
      b = POS_W'($urandom_range(1023));
      case (p)
        0: thr = POS_W'(THRESH_RESET);
        1: begin a = '0; b = 10'd1023; thr = 10'd1023; end
        2: thr = POS_W'($urandom_range(120));
        3: begin a = 10'd512; b = 10'd511; thr = '0; end
        5: thr = POS_W'($urandom_range(60));
        default: thr = POS_W'($urandom_range(1023));
      endcase
      write_settings(a, b, thr);
      for (int i = 0; i < PHASE_ITEMS; i++) queue_random_reading();
      wait_drained();
    end

    // Let anything stray show up before the verdict.
    repeat (8) @(posedge clk);
    $display("Checked %0d results from %0d requests on both channels", results_checked,
             readings_sent);
    $display("Register settings applied: %0d, across three idle patterns",
             settings_written);
    if (mismatches == 0 && expected_readings.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
